// ----- design/axis_velocity_profile_controller_top_assert.svh -----
// Assertion macros for the velocity profile controller.
`ifndef AXIS_VELOCITY_PROFILE_CONTROLLER_TOP_ASSERT_SVH
`define AXIS_VELOCITY_PROFILE_CONTROLLER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define AVPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AVPC_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AVPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define AVPC_ASSERT_NEXT(lbl, clk, ante, cons)
`endif

`endif

// ----- design/avpc_pkg.sv -----
`timescale 1ns / 1ps

package avpc_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int POS_W   = 18;
    localparam int VEL_W   = 17;
    localparam int FORCE_W = 18;
    localparam int MASS_W  = 20;
    localparam int PAR_W   = 16;
    localparam int MOP_W   = 34;
    localparam int PROD_W  = MOP_W + MASS_W;

    localparam int IN_W  = 160;
    localparam int OUT_W = 56;
    localparam int CFG_IDX_W = 3;

    localparam logic [MASS_W-1:0] MASS_RST      = 20'd311296;
    localparam logic [PAR_W-1:0]  MAX_ACCEL_RST = 16'd524;
    localparam logic [PAR_W-1:0]  MAX_SPEED_RST = 16'd2621;
    localparam logic [PAR_W-1:0]  ZVD_RST       = 16'd328;
    localparam logic [PAR_W-1:0]  MBD_RST       = 16'd655;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASS      = 3'd0,
        CFG_MAX_ACCEL = 3'd1,
        CFG_MAX_SPEED = 3'd2,
        CFG_ZVD       = 3'd3,
        CFG_MBD       = 3'd4
    } t_cfg_idx;

    // per-axis result ahead of scaling and saturation
    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic              neg;
        logic              zero;
    } t_axis_res;

    function automatic logic [FORCE_W-1:0] f_sat(input logic [PROD_W-1:0] m,
                                                 input logic neg, input logic zero);
        logic [FORCE_W-1:0] r;
        if (zero) begin
            r = '0;
        end else if (neg) begin
            if (m >= PROD_W'(131072)) r = 18'h20000;
            else r = FORCE_W'(PROD_W'(0) - m);
        end else begin
            if (m > PROD_W'(131071)) r = 18'h1FFFF;
            else r = m[FORCE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- design/axis_velocity_profile_controller_top.sv -----
`timescale 1ns / 1ps

// Three-axis bang-bang trapezoidal velocity controller.
// Slave stream: one item per control update holding position, velocity
// and goal for x, y and z. Master stream: one item per input holding the
// three saturated force commands. Settings are written through the cfg
// channel (index, data), which is always ready; write them only while idle.
// The pipeline depth comes mostly from the per-stage restoring dividers:
// FRAC_BITS+1 stages for the offset share and 34 stages for the brake and
// deceleration quotients, which run side by side.
// Throughput: one item per cycle. The pipeline advances as a whole; it
// holds when the output register is full and not being taken, and
// s_axis tready then drops, so nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and loads the
// default settings.
module axis_velocity_profile_controller_top #(
    parameter int FRAC_BITS = avpc_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, goal_x, goal_y, goal_z, pad
    input  logic [avpc_pkg::IN_W-1:0]         i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // force_x, force_y, force_z, pad
    output logic [avpc_pkg::OUT_W-1:0]        o_m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [avpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [avpc_pkg::MASS_W-1:0]       i_cfg_data
);

`include "axis_velocity_profile_controller_top_assert.svh"

    localparam int PW = avpc_pkg::POS_W;
    localparam int VW = avpc_pkg::VEL_W;
    localparam int FW = avpc_pkg::FORCE_W;
    localparam int AW = avpc_pkg::PAR_W;

    logic [avpc_pkg::MASS_W-1:0] r_mass;
    logic [AW-1:0] r_max_accel, r_max_speed, r_zvd, r_mbd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass      <= avpc_pkg::MASS_RST;
            r_max_accel <= avpc_pkg::MAX_ACCEL_RST;
            r_max_speed <= avpc_pkg::MAX_SPEED_RST;
            r_zvd       <= avpc_pkg::ZVD_RST;
            r_mbd       <= avpc_pkg::MBD_RST;
        end else if (i_cfg_valid) begin
            case (avpc_pkg::t_cfg_idx'(i_cfg_index))
                avpc_pkg::CFG_MASS:      r_mass      <= i_cfg_data;
                avpc_pkg::CFG_MAX_ACCEL: r_max_accel <= i_cfg_data[AW-1:0];
                avpc_pkg::CFG_MAX_SPEED: r_max_speed <= i_cfg_data[AW-1:0];
                avpc_pkg::CFG_ZVD:       r_zvd       <= i_cfg_data[AW-1:0];
                avpc_pkg::CFG_MBD:       r_mbd       <= i_cfg_data[AW-1:0];
                default: ;
            endcase
        end
    end

    logic w_ce;
    logic r_out_vld;

    assign w_ce            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_ce;

    // offsets and magnitudes
    logic [PW-1:0] w_pos  [3];
    logic [PW-1:0] w_goal [3];
    logic [VW-1:0] w_vel  [3];
    logic [PW:0]   w_d    [3];
    logic [PW-1:0] w_ad   [3];
    logic [VW-1:0] w_av   [3];
    logic [PW-1:0] w_maxd;

    logic          r0_vld;
    logic [PW-1:0] r0_ad [3];
    logic [VW-1:0] r0_av [3];
    logic [2:0]    r0_dpos, r0_vpos;
    logic [PW-1:0] r0_maxd;

    for (genvar a = 0; a < 3; a++) begin : g_in
        assign w_pos[a]  = i_s_axis_tdata[a*PW +: PW];
        assign w_vel[a]  = i_s_axis_tdata[3*PW + a*VW +: VW];
        assign w_goal[a] = i_s_axis_tdata[3*PW + 3*VW + a*PW +: PW];
        assign w_d[a]    = (PW+1)'($signed(w_goal[a])) - (PW+1)'($signed(w_pos[a]));
        assign w_ad[a]   = w_d[a][PW] ? PW'((PW+1)'(0) - w_d[a]) : w_d[a][PW-1:0];
        assign w_av[a]   = w_vel[a][VW-1] ? VW'(0) - w_vel[a] : w_vel[a];

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r0_ad[a]   <= w_ad[a];
                r0_av[a]   <= w_av[a];
                r0_dpos[a] <= !w_d[a][PW] && (w_d[a] != '0);
                r0_vpos[a] <= !w_vel[a][VW-1] && (w_vel[a] != '0);
            end
        end
    end

    always_comb begin
        w_maxd = w_ad[0];
        if (w_ad[1] > w_maxd) w_maxd = w_ad[1];
        if (w_ad[2] > w_maxd) w_maxd = w_ad[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (w_ce) begin
            r0_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r0_maxd <= w_maxd;
        end
    end

    logic [2:0]          w_ax_vld;
    avpc_pkg::t_axis_res w_ax_res [3];
    logic                w_last_vld;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        avpc_axis #(.FRAC_BITS(FRAC_BITS)) u_axis (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ce        (w_ce),
            .i_vld       (r0_vld),
            .i_ad        (r0_ad[a]),
            .i_av        (r0_av[a]),
            .i_dpos      (r0_dpos[a]),
            .i_vpos      (r0_vpos[a]),
            .i_maxd      (r0_maxd),
            .i_mass      (r_mass),
            .i_max_accel (r_max_accel),
            .i_max_speed (r_max_speed),
            .i_zvd       (r_zvd),
            .i_mbd       (r_mbd),
            .o_vld       (w_ax_vld[a]),
            .o_res       (w_ax_res[a])
        );
    end

    assign w_last_vld = &w_ax_vld;

    logic [FW-1:0] r_force [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ce) begin
            r_out_vld <= w_last_vld;
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_out
        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_force[a] <= avpc_pkg::f_sat(w_ax_res[a].prod >> FRAC_BITS,
                                              w_ax_res[a].neg, w_ax_res[a].zero);
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {2'b00, r_force[2], r_force[1], r_force[0]};

    `AVPC_ASSERT_NEXT(a_rst_empties, i_clk, !i_rst_n, !o_m_axis_tvalid)
    `AVPC_ASSERT_IMPL(a_stall_blocks, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, !o_s_axis_tready)
    `AVPC_ASSERT_IMPL(a_out_from_pipe, i_clk, i_rst_n, $rose(o_m_axis_tvalid), $past(w_last_vld))

endmodule

// ----- design/avpc_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage. Quotient must fit QW bits.
module avpc_div #(
    parameter int NW = 34,
    parameter int DW = 17,
    parameter int QW = 34,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_sb,
    output logic          o_vld,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_sb
);

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_num [QW];
    logic [QW-1:0] r_quo [QW];
    logic [DW-1:0] r_den [QW];
    logic [SW-1:0] r_sb  [QW];
    logic [QW-1:0] r_vld;

    logic [NW+DW-1:0] w_ext;
    logic [DW-1:0]    w_rem0;

    assign w_ext  = {{DW{1'b0}}, i_num};
    assign w_rem0 = DW'(w_ext >> QW);

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] s_rem;
        logic [QW-1:0] s_num;
        logic [QW-1:0] s_quo;
        logic [DW-1:0] s_den;
        logic [SW-1:0] s_sb;
        logic          s_vld;
        logic [DW:0]   w_trial;
        logic [DW:0]   w_diff;
        logic          w_ge;
        logic [DW-1:0] n_rem;

        if (k == 0) begin : g_first
            assign s_rem = w_rem0;
            assign s_num = i_num[QW-1:0];
            assign s_quo = '0;
            assign s_den = i_den;
            assign s_sb  = i_sb;
            assign s_vld = i_vld;
        end else begin : g_next
            assign s_rem = r_rem[k-1];
            assign s_num = r_num[k-1];
            assign s_quo = r_quo[k-1];
            assign s_den = r_den[k-1];
            assign s_sb  = r_sb[k-1];
            assign s_vld = r_vld[k-1];
        end

        assign w_trial = {s_rem, s_num[QW-1]};
        assign w_ge    = w_trial >= {1'b0, s_den};
        assign w_diff  = w_trial - {1'b0, s_den};
        assign n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ce) begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k] <= n_rem;
                r_num[k] <= s_num << 1;
                r_quo[k] <= {s_quo[QW-2:0], w_ge};
                r_den[k] <= s_den;
                r_sb[k]  <= s_sb;
            end
        end
    end

    assign o_vld = r_vld[QW-1];
    assign o_quo = r_quo[QW-1];
    assign o_sb  = r_sb[QW-1];

endmodule

// ----- design/avpc_axis.sv -----
`timescale 1ns / 1ps

module avpc_axis #(
    parameter int FRAC_BITS = avpc_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  logic                          i_vld,
    input  logic [avpc_pkg::POS_W-1:0]    i_ad,
    input  logic [avpc_pkg::VEL_W-1:0]    i_av,
    input  logic                          i_dpos,
    input  logic                          i_vpos,
    input  logic [avpc_pkg::POS_W-1:0]    i_maxd,
    input  logic [avpc_pkg::MASS_W-1:0]   i_mass,
    input  logic [avpc_pkg::PAR_W-1:0]    i_max_accel,
    input  logic [avpc_pkg::PAR_W-1:0]    i_max_speed,
    input  logic [avpc_pkg::PAR_W-1:0]    i_zvd,
    input  logic [avpc_pkg::PAR_W-1:0]    i_mbd,
    output logic                          o_vld,
    output avpc_pkg::t_axis_res           o_res
);

    localparam int PW  = avpc_pkg::POS_W;
    localparam int VW  = avpc_pkg::VEL_W;
    localparam int AW  = avpc_pkg::PAR_W;
    localparam int MW  = avpc_pkg::MOP_W;
    localparam int PFW = FRAC_BITS + 1;
    localparam int NW1 = PW + FRAC_BITS;
    localparam int SB1 = PW + VW + 3;
    localparam int SB2 = PW + VW + AW + AW + 1;
    localparam int BNW = MW + 2;

    // share of the largest offset
    logic           w_mz;
    logic           w1_vld;
    logic [PFW-1:0] w1_quo;
    logic [SB1-1:0] w1_sb;

    assign w_mz = (i_maxd == '0);

    avpc_div #(.NW(NW1), .DW(PW), .QW(PFW), .SW(SB1)) u_div_pf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (i_ce),
        .i_vld   (i_vld),
        .i_num   ({i_ad, {FRAC_BITS{1'b0}}}),
        .i_den   (i_maxd),
        .i_sb    ({i_ad, i_av, i_dpos, i_vpos, w_mz}),
        .o_vld   (w1_vld),
        .o_quo   (w1_quo),
        .o_sb    (w1_sb)
    );

    logic [PW-1:0]  w1_ad;
    logic [VW-1:0]  w1_av;
    logic           w1_dpos, w1_vpos, w1_mz;
    logic [PFW-1:0] w1_pf;
    logic [AW+PFW-1:0] w1_limp, w1_accp;

    assign {w1_ad, w1_av, w1_dpos, w1_vpos, w1_mz} = w1_sb;
    assign w1_pf   = w1_mz ? '0 : w1_quo;
    assign w1_limp = i_max_speed * w1_pf;
    assign w1_accp = i_max_accel * w1_pf;

    // speed limit, acceleration, v squared
    logic          r1_vld;
    logic [AW-1:0] r1_lim, r1_acc;
    logic [MW-1:0] r1_avsq;
    logic [PW-1:0] r1_ad;
    logic [VW-1:0] r1_av;
    logic          r1_dpos, r1_vpos;

    // look-ahead speed
    logic          r2_vld;
    logic [VW-1:0] r2_s;
    logic [AW-1:0] r2_lim, r2_acc;
    logic [MW-1:0] r2_avsq;
    logic [PW-1:0] r2_ad;
    logic [VW-1:0] r2_av;
    logic          r2_dpos, r2_vpos;

    // s squared
    logic          r3_vld;
    logic [MW-1:0] r3_sq;
    logic [AW-1:0] r3_lim, r3_acc;
    logic [MW-1:0] r3_avsq;
    logic [PW-1:0] r3_ad;
    logic [VW-1:0] r3_av;
    logic          r3_dpos, r3_vpos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_ce) begin
            r1_vld <= w1_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_lim  <= w1_limp[FRAC_BITS+AW-1:FRAC_BITS];
            r1_acc  <= w1_accp[FRAC_BITS+AW-1:FRAC_BITS];
            r1_avsq <= MW'(w1_av * w1_av);
            r1_ad   <= w1_ad;
            r1_av   <= w1_av;
            r1_dpos <= w1_dpos;
            r1_vpos <= w1_vpos;

            r2_s    <= r1_av + VW'(r1_acc);
            r2_lim  <= r1_lim;
            r2_acc  <= r1_acc;
            r2_avsq <= r1_avsq;
            r2_ad   <= r1_ad;
            r2_av   <= r1_av;
            r2_dpos <= r1_dpos;
            r2_vpos <= r1_vpos;

            r3_sq   <= MW'(r2_s * r2_s);
            r3_lim  <= r2_lim;
            r3_acc  <= r2_acc;
            r3_avsq <= r2_avsq;
            r3_ad   <= r2_ad;
            r3_av   <= r2_av;
            r3_dpos <= r2_dpos;
            r3_vpos <= r2_vpos;
        end
    end

    // divisors: zero taken as one LSB
    logic [AW:0] w_bdiv;
    logic [PW:0] w_dd;

    assign w_bdiv = (i_max_accel == '0) ? (AW+1)'(1) : {i_max_accel, 1'b0};
    assign w_dd   = (r3_ad == '0) ? (PW+1)'(1) : {r3_ad, 1'b0};

    logic           w2_vld;
    logic [MW-1:0]  w2_quo;
    logic [SB2-1:0] w2_sb;
    logic           w3_vld;
    logic [MW-1:0]  w3_dec;
    logic           w3_dpos;

    avpc_div #(.NW(MW), .DW(AW+1), .QW(MW), .SW(SB2)) u_div_brake (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (i_ce),
        .i_vld   (r3_vld),
        .i_num   (r3_sq),
        .i_den   (w_bdiv),
        .i_sb    ({r3_ad, r3_av, r3_acc, r3_lim, r3_vpos}),
        .o_vld   (w2_vld),
        .o_quo   (w2_quo),
        .o_sb    (w2_sb)
    );

    avpc_div #(.NW(MW), .DW(PW+1), .QW(MW), .SW(1)) u_div_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (i_ce),
        .i_vld   (r3_vld),
        .i_num   (r3_avsq),
        .i_den   (w_dd),
        .i_sb    (r3_dpos),
        .o_vld   (w3_vld),
        .o_quo   (w3_dec),
        .o_sb    (w3_dpos)
    );

    logic [PW-1:0]  w4_ad;
    logic [VW-1:0]  w4_av;
    logic [AW-1:0]  w4_acc, w4_lim;
    logic           w4_vpos;
    logic [BNW-1:0] w4_bnum;
    logic [PW:0]    w4_ad2;
    logic           w4_c1, w4_c2, w4_c3;

    assign {w4_ad, w4_av, w4_acc, w4_lim, w4_vpos} = w2_sb;
    assign w4_bnum = {1'b0, w2_quo, 1'b0} + BNW'({w4_av, 1'b0}) + BNW'(w4_acc);
    assign w4_ad2  = {w4_ad, 1'b0};
    assign w4_c1   = PW'(i_zvd) > w4_ad;
    assign w4_c2   = (w4_ad2 < (PW+1)'({i_mbd, 1'b0})) || (BNW'(w4_ad2) < w4_bnum);
    assign w4_c3   = (w4_av < VW'(w4_lim)) || (w4_vpos != w3_dpos);

    // case select, then force magnitude
    logic          r4_vld;
    logic [MW-1:0] r4_mop;
    logic          r4_neg, r4_zero;
    logic          r5_vld;
    logic [avpc_pkg::PROD_W-1:0] r5_prod;
    logic          r5_neg, r5_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_ce) begin
            r4_vld <= w2_vld & w3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            if (w4_c1) begin
                r4_mop  <= MW'(w4_av);
                r4_neg  <= w4_vpos;
                r4_zero <= 1'b0;
            end else if (w4_c2) begin
                r4_mop  <= w3_dec;
                r4_neg  <= w4_vpos;
                r4_zero <= 1'b0;
            end else if (w4_c3) begin
                r4_mop  <= MW'(w4_acc);
                r4_neg  <= !w3_dpos;
                r4_zero <= 1'b0;
            end else begin
                r4_mop  <= '0;
                r4_neg  <= 1'b0;
                r4_zero <= 1'b1;
            end
            r5_prod <= r4_mop * i_mass;
            r5_neg  <= r4_neg;
            r5_zero <= r4_zero;
        end
    end

    assign o_vld      = r5_vld;
    assign o_res.prod = r5_prod;
    assign o_res.neg  = r5_neg;
    assign o_res.zero = r5_zero;

endmodule
